// File: design/framed_request_reply_session_top_assert.svh
// Assertion macros shared by the session checker.
`ifndef FRAMED_REQUEST_REPLY_SESSION_TOP_ASSERT_SVH
`define FRAMED_REQUEST_REPLY_SESSION_TOP_ASSERT_SVH
// Implication in the same cycle, sampled on clk, off during reset.
`define FRRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication into the next cycle.
`define FRRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: design/frrs_pkg.sv
// Types, codes and header helper for the framed request/reply session block.
`timescale 1ns / 1ps
package frrs_pkg;
	// Input modes.
	localparam logic [2:0] MODE_START   = 3'd0;
	localparam logic [2:0] MODE_REQ     = 3'd1;
	localparam logic [2:0] MODE_RX      = 3'd2;
	localparam logic [2:0] MODE_LOST    = 3'd3;
	localparam logic [2:0] MODE_CONF    = 3'd4;
	localparam logic [2:0] MODE_CANCEL  = 3'd5;
	localparam logic [2:0] MODE_TICK    = 3'd6;

	// Result kinds.
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REPLY  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes.
	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_CANCEL   = 4'd2;
	localparam logic [3:0] ST_TIMEOUT  = 4'd3;
	localparam logic [3:0] ST_LOST     = 4'd4;
	localparam logic [3:0] ST_HEADER   = 4'd5;
	localparam logic [3:0] ST_LENGTH   = 4'd6;
	localparam logic [3:0] ST_EXCESS   = 4'd7;
	localparam logic [3:0] ST_NONASCII = 4'd8;
	localparam logic [3:0] ST_BADREQ   = 4'd9;

	// Header bursts attached to a command.
	localparam logic [1:0] BURST_NONE = 2'd0;
	localparam logic [1:0] BURST_REQ  = 2'd1;
	localparam logic [1:0] BURST_ACK  = 2'd2;

	// Header type bytes.
	localparam logic [7:0] HTYPE_REQ   = 8'd1;
	localparam logic [7:0] HTYPE_REPLY = 8'd2;
	localparam logic [7:0] HTYPE_ACK   = 8'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_SESSION_ID = 2'd0;
	localparam logic [1:0] REG_REQ_LENGTH = 2'd1;
	localparam logic [1:0] REG_TIMEOUT    = 2'd2;

	// Command queue depth between front and back.
	localparam int QDEPTH = 4;

	// One command: an optional single result, then an optional header burst.
	typedef struct packed {
		logic        lead;
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        tx_end;
		logic [3:0]  status;
		logic [1:0]  burst;
		logic [10:0] len;
		logic [31:0] id;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       tx_end;
		logic [3:0] status;
		logic       last;
	} res_t;

	// Byte at a position of a 16-byte header.
	function automatic logic [7:0] hdr_byte(input logic [3:0] pos, input logic [7:0] htype,
		input logic [31:0] id, input logic [10:0] len);
		logic [31:0] l;
		logic [7:0]  r;
		l = {21'd0, len};
		unique case (pos)
			4'd0:  r = 8'h4B;
			4'd1:  r = 8'h41;
			4'd2:  r = 8'h49;
			4'd3:  r = 8'h31;
			4'd4:  r = htype;
			4'd5, 4'd6, 4'd7: r = 8'd0;
			4'd8:  r = id[31:24];
			4'd9:  r = id[23:16];
			4'd10: r = id[15:8];
			4'd11: r = id[7:0];
			4'd12: r = l[31:24];
			4'd13: r = l[23:16];
			4'd14: r = l[15:8];
			default: r = l[7:0];
		endcase
		return r;
	endfunction
endpackage

// File: design/frrs_front.sv
// Front part: session state machine that takes items and issues commands.
`timescale 1ns / 1ps
module frrs_front #(
	parameter int REPLY_MAX    = 4096,
	parameter int REQUEST_MAX  = 1024,
	parameter int PACKET_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_take,
	input  logic [2:0]         mode,
	input  logic [7:0]         data_byte,
	input  logic               rx_packet_end,
	input  logic [31:0]        session_id,
	input  logic [10:0]        request_length,
	input  logic [15:0]        timeout_ticks,
	output logic               cmd_push,
	output frrs_pkg::cmd_t     cmd
);
	import frrs_pkg::*;

	localparam int RCW = $clog2(REPLY_MAX + 1);
	localparam int PPW = $clog2(PACKET_BYTES);
	localparam logic [PPW-1:0] PP_START = (PACKET_BYTES == 16) ? '0 : PPW'(16);
	localparam logic [PPW-1:0] PP_LAST  = PPW'(PACKET_BYTES - 1);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_SEND = 3'd1;
	localparam logic [2:0] PH_RECV = 3'd2;
	localparam logic [2:0] PH_TAIL = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	logic [2:0]     phase_q, phase_d;
	logic [10:0]    sent_q, sent_d;
	logic [PPW-1:0] pkt_pos_q, pkt_pos_d;
	logic [4:0]     hidx_q, hidx_d;
	logic [31:0]    exp_q, exp_d;
	logic [RCW-1:0] rcnt_q, rcnt_d;
	logic           rflag_q, rflag_d;
	logic [15:0]    tick_q, tick_d;
	logic           conn_q, conn_d;

	logic           active;
	logic           ok;
	logic [31:0]    exp_new;
	logic [RCW:0]   rcnt_inc;
	logic [11:0]    sent_inc;
	logic [15:0]    tick_inc;
	logic           printable;

	assign active    = (phase_q != PH_IDLE);
	assign exp_new   = {exp_q[23:0], data_byte};
	assign rcnt_inc  = {1'b0, rcnt_q} + 1'b1;
	assign sent_inc  = {1'b0, sent_q} + 12'd1;
	assign tick_inc  = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
	assign printable = (data_byte == 8'd9) || (data_byte == 8'd10) || (data_byte == 8'd13) ||
		((data_byte >= 8'd32) && (data_byte <= 8'd126));

	// Header check for the current reply header position.
	always_comb begin
		ok = 1'b1;
		if (hidx_q < 5'd4 || (hidx_q >= 5'd8 && hidx_q < 5'd12))
			ok = (data_byte == hdr_byte(hidx_q[3:0], 8'd0, session_id, 11'd0));
		else if (hidx_q == 5'd4)
			ok = (data_byte == HTYPE_REPLY);
		else if (hidx_q == 5'd5)
			ok = (data_byte <= 8'd1);
		else if (hidx_q == 5'd6 || hidx_q == 5'd7)
			ok = (data_byte == 8'd0);
	end

	// Next state and command for the item taken this cycle.
	always_comb begin
		phase_d   = phase_q;
		sent_d    = sent_q;
		pkt_pos_d = pkt_pos_q;
		hidx_d    = hidx_q;
		exp_d     = exp_q;
		rcnt_d    = rcnt_q;
		rflag_d   = rflag_q;
		tick_d    = tick_q;
		conn_d    = conn_q;
		cmd_push  = 1'b0;
		cmd.lead   = 1'b1;
		cmd.kind   = KIND_STATUS;
		cmd.data   = 8'd0;
		cmd.tx_end = 1'b0;
		cmd.status = ST_OK;
		cmd.burst  = BURST_NONE;
		cmd.len    = request_length;
		cmd.id     = session_id;
		if (in_take) begin
			unique case (mode)
				MODE_START: begin
					if (!active) begin
						cmd_push = 1'b1;
						if (request_length == 11'd0 || request_length > 11'(REQUEST_MAX)) begin
							cmd.status = ST_BADREQ;
						end else begin
							cmd.lead  = 1'b0;
							cmd.burst = BURST_REQ;
							sent_d    = '0;
							pkt_pos_d = PP_START;
							hidx_d    = '0;
							exp_d     = '0;
							rcnt_d    = '0;
							rflag_d   = 1'b0;
							tick_d    = '0;
							phase_d   = PH_SEND;
						end
					end
				end
				MODE_REQ: begin
					if (phase_q == PH_SEND) begin
						cmd_push   = 1'b1;
						cmd.kind   = KIND_TX;
						cmd.data   = data_byte;
						cmd.tx_end = (pkt_pos_q == PP_LAST) || (sent_inc >= {1'b0, request_length});
						pkt_pos_d  = (pkt_pos_q == PP_LAST) ? '0 : pkt_pos_q + 1'b1;
						sent_d     = sent_inc[10:0];
						if (sent_inc[10:0] >= request_length)
							phase_d = PH_RECV;
					end
				end
				MODE_RX: begin
					if (phase_q == PH_TAIL) begin
						cmd_push   = 1'b1;
						cmd.status = ST_EXCESS;
						phase_d    = PH_IDLE;
					end else if (phase_q == PH_RECV) begin
						if (hidx_q < 5'd16) begin
							if (!ok || (rx_packet_end && hidx_q < 5'd15)) begin
								cmd_push   = 1'b1;
								cmd.status = ST_HEADER;
								phase_d    = PH_IDLE;
							end else begin
								if (hidx_q == 5'd5)
									rflag_d = data_byte[0];
								if (hidx_q >= 5'd12)
									exp_d = exp_new;
								hidx_d = hidx_q + 5'd1;
								if (hidx_q == 5'd15 &&
									(exp_new == 32'd0 || exp_new > 32'(REPLY_MAX))) begin
									cmd_push   = 1'b1;
									cmd.status = ST_LENGTH;
									phase_d    = PH_IDLE;
								end
							end
						end else if (!printable) begin
							cmd_push   = 1'b1;
							cmd.status = ST_NONASCII;
							phase_d    = PH_IDLE;
						end else begin
							cmd_push = 1'b1;
							cmd.kind = KIND_REPLY;
							cmd.data = data_byte;
							rcnt_d   = rcnt_inc[RCW-1:0];
							if ({{(31-RCW){1'b0}}, rcnt_inc} >= exp_q) begin
								if (rx_packet_end) begin
									phase_d   = PH_DONE;
									cmd.burst = BURST_ACK;
									cmd.len   = 11'd0;
								end else begin
									phase_d = PH_TAIL;
								end
							end
						end
					end
				end
				MODE_LOST: begin
					if (phase_q == PH_DONE) begin
						cmd_push   = 1'b1;
						cmd.status = {3'd0, rflag_q};
						phase_d    = PH_IDLE;
					end else if (active && conn_q) begin
						cmd_push   = 1'b1;
						cmd.status = ST_LOST;
						phase_d    = PH_IDLE;
					end
					conn_d = 1'b0;
				end
				MODE_CONF: conn_d = 1'b1;
				MODE_CANCEL: begin
					if (active) begin
						cmd_push   = 1'b1;
						cmd.status = ST_CANCEL;
						phase_d    = PH_IDLE;
					end
				end
				MODE_TICK: begin
					if (active) begin
						tick_d = tick_inc;
						if (tick_inc >= timeout_ticks) begin
							cmd_push   = 1'b1;
							cmd.status = ST_TIMEOUT;
							phase_d    = PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Session state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sent_q    <= '0;
			pkt_pos_q <= PP_START;
			hidx_q    <= '0;
			exp_q     <= '0;
			rcnt_q    <= '0;
			rflag_q   <= 1'b0;
			tick_q    <= '0;
			conn_q    <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			sent_q    <= sent_d;
			pkt_pos_q <= pkt_pos_d;
			hidx_q    <= hidx_d;
			exp_q     <= exp_d;
			rcnt_q    <= rcnt_d;
			rflag_q   <= rflag_d;
			tick_q    <= tick_d;
			conn_q    <= conn_d;
		end
	end
endmodule

// File: design/frrs_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module frrs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  frrs_pkg::cmd_t wdata,
	input  logic           pop,
	output frrs_pkg::cmd_t head,
	output logic           full,
	output logic           nempty
);
	import frrs_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	cmd_t          mem_q [QDEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;

	assign full   = (cnt_q == (AW+1)'(QDEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: design/frrs_back.sv
// Back part: expands commands into result items behind an output register.
`timescale 1ns / 1ps
module frrs_back #(
	parameter int PACKET_BYTES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  frrs_pkg::cmd_t head,
	input  logic           head_valid,
	output logic           head_pop,
	input  logic           pop,
	output logic           empty,
	output frrs_pkg::res_t res
);
	import frrs_pkg::*;

	logic [4:0] idx_q;
	logic [4:0] p5;
	logic [3:0] pos;
	logic       single;
	logic       gen_last;
	logic       load;
	res_t       gen;
	res_t       res_q;
	logic       empty_q;

	assign p5     = idx_q - {4'd0, head.lead};
	assign pos    = p5[3:0];
	assign single = head.lead && (idx_q == 5'd0);
	assign load   = empty_q || pop;

	// Result for the current step of the head command.
	always_comb begin
		if (single) begin
			gen.kind     = head.kind;
			gen.out_byte = head.data;
			gen.tx_end   = head.tx_end;
			gen.status   = head.status;
			gen_last     = (head.burst == BURST_NONE);
		end else begin
			gen.kind     = KIND_TX;
			gen.out_byte = hdr_byte(pos, (head.burst == BURST_ACK) ? HTYPE_ACK : HTYPE_REQ,
				head.id, head.len);
			gen.tx_end   = (pos == 4'd15) &&
				((head.burst == BURST_ACK) || (PACKET_BYTES == 16));
			gen.status   = ST_OK;
			gen_last     = (pos == 4'd15);
		end
		gen.last = gen_last;
	end

	assign head_pop = load && head_valid && gen_last;
	assign empty    = empty_q;
	assign res      = res_q;

	// Step counter within a command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (load && head_valid)
			idx_q <= gen_last ? 5'd0 : idx_q + 5'd1;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			empty_q <= 1'b1;
		else if (load)
			empty_q <= !head_valid;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= gen;
	end
endmodule

// File: design/framed_request_reply_session_top.sv
// Top level of the framed request/reply session block.
// Takes one item per cycle while the command queue has room. Every item
// yields at most one command; the back part turns a command into its
// results at one result per cycle while results are popped, so a start or
// an acknowledge yields sixteen (or seventeen) results and the four-entry
// command queue is what lets the front keep taking items meanwhile. Registers
// are read live and are written over the APB port, pready is always high.
`timescale 1ns / 1ps
module framed_request_reply_session_top #(
	parameter int REPLY_MAX    = 4096,
	parameter int REQUEST_MAX  = 1024,
	parameter int PACKET_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic        rx_packet_end,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic        tx_packet_end,
	output logic [3:0]  status,
	output logic        last
);
	import frrs_pkg::*;

	logic [31:0] sid_q;
	logic [10:0] rlen_q;
	logic [15:0] tmo_q;
	logic        wr;
	logic        in_take;
	logic        cmd_push;
	cmd_t        cmd;
	cmd_t        head;
	logic        head_valid;
	logic        head_pop;
	res_t        res;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sid_q  <= 32'd1;
			rlen_q <= 11'd1;
			tmo_q  <= 16'd15360;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_SESSION_ID: sid_q  <= pwdata;
				REG_REQ_LENGTH: rlen_q <= pwdata[10:0];
				REG_TIMEOUT:    tmo_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_SESSION_ID: prdata = sid_q;
			REG_REQ_LENGTH: prdata = {21'd0, rlen_q};
			REG_TIMEOUT:    prdata = {16'd0, tmo_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign in_take = push && !full;

	frrs_front #(
		.REPLY_MAX(REPLY_MAX), .REQUEST_MAX(REQUEST_MAX), .PACKET_BYTES(PACKET_BYTES)
	) u_front (
		.clk(clk), .arst_n(arst_n), .in_take(in_take), .mode(mode),
		.data_byte(data_byte), .rx_packet_end(rx_packet_end),
		.session_id(sid_q), .request_length(rlen_q), .timeout_ticks(tmo_q),
		.cmd_push(cmd_push), .cmd(cmd)
	);

	frrs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(cmd_push), .wdata(cmd), .pop(head_pop),
		.head(head), .full(full), .nempty(head_valid)
	);

	frrs_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid),
		.head_pop(head_pop), .pop(pop), .empty(empty), .res(res)
	);

	assign kind          = res.kind;
	assign out_byte      = res.out_byte;
	assign tx_packet_end = res.tx_end;
	assign status        = res.status;
	assign last          = res.last;
endmodule

// File: design/frrs_checker.sv
// Port-level checker for the session block, bound to the top level.
`timescale 1ns / 1ps
`include "framed_request_reply_session_top_assert.svh"
module frrs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic       tx_packet_end,
	input logic [3:0] status,
	input logic       last
);
	import frrs_pkg::*;

	// A status item is a bare, final item.
	`FRRS_ASSERT_NOW(a_status_shape, !empty && kind == KIND_STATUS, out_byte == 8'd0 && !tx_packet_end && last, "status item malformed")
	// Reply items carry no status and no packet end.
	`FRRS_ASSERT_NOW(a_reply_shape, !empty && kind == KIND_REPLY, status == ST_OK && !tx_packet_end, "reply item malformed")
	// Transmit items carry no status.
	`FRRS_ASSERT_NOW(a_tx_shape, !empty && kind == KIND_TX, status == ST_OK, "transmit item with status")
	// A waiting item holds while not taken.
	`FRRS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(kind), "waiting item changed")
endmodule

bind framed_request_reply_session_top frrs_checker u_frrs_checker (.*);

// File: dv/framed_request_reply_session_top_tb.sv
// Self-checking testbench for the framed request/reply session block.
`timescale 1ns / 1ps
module framed_request_reply_session_top_tb;
	import frrs_pkg::*;

	localparam int          PKT_BYTES   = 64;
	localparam int          REPLY_LIMIT = 4096;
	localparam int          REQ_LIMIT   = 1024;
	localparam logic [3:0]  ST_REMOTE   = 4'd1;
	localparam logic [2:0]  MODE_UNUSED = 3'd7;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          DRAIN_WAIT  = 120;

	typedef enum logic [2:0] {SS_IDLE, SS_SEND, SS_RECV, SS_TAIL, SS_DONE} sess_phase_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push;
	logic        full;
	logic [2:0]  mode;
	logic [7:0]  data_byte;
	logic        rx_packet_end;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic        tx_packet_end;
	logic [3:0]  status;
	logic        last;

	framed_request_reply_session_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .mode(mode), .data_byte(data_byte),
		.rx_packet_end(rx_packet_end), .empty(empty), .pop(pop), .kind(kind),
		.out_byte(out_byte), .tx_packet_end(tx_packet_end), .status(status), .last(last)
	);

	// Register shadows and session state of the predictor.
	logic [31:0]  cfg_id;
	logic [10:0]  cfg_req_len;
	logic [15:0]  cfg_ticks;
	sess_phase_t  s_phase;
	logic [10:0]  s_sent;
	logic [4:0]   s_hdr_idx;
	logic [31:0]  s_reply_len;
	logic [12:0]  s_recv;
	logic         s_remote;
	logic         s_first_pkt;
	logic [15:0]  s_ticks;
	logic         s_connected;

	res_t expected_results[$];
	int   fail_count;
	int   items_sent;
	int   cycle_count;
	bit   idle_enable;
	bit   hold_go;
	logic hold_pop;
	int   pop_stall;

	// Clock.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Byte at one position of a 16-byte header, built from the current id.
	function automatic logic [7:0] header_at(input int pos, input logic [7:0] htype,
		input logic [31:0] hlen);
		logic [7:0] r;
		case (pos)
			0: r = "K";
			1: r = "A";
			2: r = "I";
			3: r = "1";
			4: r = htype;
			5, 6, 7: r = 8'd0;
			8, 9, 10, 11: r = 8'(cfg_id >> (8 * (11 - pos)));
			default: r = 8'(hlen >> (8 * (15 - pos)));
		endcase
		return r;
	endfunction

	function automatic res_t make_res(input logic [1:0] k, input logic [7:0] b,
		input logic e, input logic [3:0] st);
		res_t r;
		r.kind = k;
		r.out_byte = b;
		r.tx_end = e;
		r.status = st;
		r.last = 1'b0;
		return r;
	endfunction

	// Works out the results of one accepted item and advances the session state.
	function automatic void predict_session(input logic [2:0] m, input logic [7:0] b,
		input logic pend);
		res_t out_q[$];
		res_t r;
		bit   active;
		bit   ok;
		int   h;
		active = s_phase != SS_IDLE;
		case (m)
			MODE_START: begin
				if (!active) begin
					if (cfg_req_len < 1 || cfg_req_len > REQ_LIMIT) begin
						out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_BADREQ));
						s_phase = SS_IDLE;
					end else begin
						s_sent = 0;
						s_hdr_idx = 0;
						s_reply_len = 0;
						s_recv = 0;
						s_remote = 0;
						s_first_pkt = 1;
						s_ticks = 0;
						s_phase = SS_SEND;
						for (int i = 0; i < 16; i++)
							out_q.push_back(make_res(KIND_TX,
								header_at(i, HTYPE_REQ, {21'd0, cfg_req_len}),
								((i + 1) % PKT_BYTES) == 0, ST_OK));
					end
				end
			end
			MODE_REQ: begin
				if (s_phase == SS_SEND) begin
					out_q.push_back(make_res(KIND_TX, b,
						((16 + s_sent + 1) % PKT_BYTES) == 0 || s_sent + 1 >= cfg_req_len,
						ST_OK));
					s_sent = s_sent + 11'd1;
					if (s_sent >= cfg_req_len)
						s_phase = SS_RECV;
				end
			end
			MODE_RX: begin
				if (s_phase == SS_TAIL) begin
					out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_EXCESS));
					s_phase = SS_IDLE;
				end else if (s_phase == SS_RECV && s_hdr_idx < 16) begin
					h = s_hdr_idx;
					if (h < 4 || (h >= 8 && h < 12))
						ok = b == header_at(h, 8'd0, 32'd0);
					else if (h == 4)
						ok = b == HTYPE_REPLY;
					else if (h == 5)
						ok = b <= 1;
					else if (h == 6 || h == 7)
						ok = b == 0;
					else
						ok = 1;
					if (!ok || (pend && h < 15)) begin
						out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_HEADER));
						s_phase = SS_IDLE;
					end else begin
						if (h == 5)
							s_remote = b[0];
						if (h >= 12)
							s_reply_len = {s_reply_len[23:0], b};
						s_hdr_idx = 5'(h + 1);
						if (pend)
							s_first_pkt = 0;
						if (s_hdr_idx == 16 && (s_reply_len == 0 || s_reply_len > REPLY_LIMIT)) begin
							out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_LENGTH));
							s_phase = SS_IDLE;
						end
					end
				end else if (s_phase == SS_RECV) begin
					if (!(b == 9 || b == 10 || b == 13 || (b >= 32 && b <= 126))) begin
						out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_NONASCII));
						s_phase = SS_IDLE;
					end else begin
						out_q.push_back(make_res(KIND_REPLY, b, 1'b0, ST_OK));
						s_recv = s_recv + 13'd1;
						if (pend)
							s_first_pkt = 0;
						if (s_recv >= s_reply_len) begin
							if (pend) begin
								s_phase = SS_DONE;
								for (int i = 0; i < 16; i++)
									out_q.push_back(make_res(KIND_TX,
										header_at(i, HTYPE_ACK, 32'd0), i == 15, ST_OK));
							end else begin
								s_phase = SS_TAIL;
							end
						end
					end
				end
			end
			MODE_LOST: begin
				if (s_phase == SS_DONE) begin
					out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0,
						s_remote ? ST_REMOTE : ST_OK));
					s_phase = SS_IDLE;
				end else if (active && s_connected) begin
					out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_LOST));
					s_phase = SS_IDLE;
				end
				s_connected = 0;
			end
			MODE_CONF: s_connected = 1;
			MODE_CANCEL: begin
				if (active) begin
					out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_CANCEL));
					s_phase = SS_IDLE;
				end
			end
			MODE_TICK: begin
				if (active) begin
					if (s_ticks != 16'hFFFF)
						s_ticks = s_ticks + 16'd1;
					if (s_ticks >= cfg_ticks) begin
						out_q.push_back(make_res(KIND_STATUS, 8'd0, 1'b0, ST_TIMEOUT));
						s_phase = SS_IDLE;
					end
				end
			end
			default: ;
		endcase
		// The final result of the item carries the last mark.
		if (out_q.size() > 0) begin
			r = out_q.pop_back();
			r.last = 1'b1;
			out_q.push_back(r);
		end
		foreach (out_q[i])
			expected_results.push_back(out_q[i]);
	endfunction

	// Offers one item, waits for it to be taken, then maybe idles for a burst.
	task automatic send_item(input logic [2:0] m, input logic [7:0] b, input logic pend);
		mode <= m;
		data_byte <= b;
		rx_packet_end <= pend;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		predict_session(m, b, pend);
		items_sent++;
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Sends an item, with random noise before it and rare corruption when faulty.
	task automatic send_noisy(input bit faulty, input logic [2:0] m, input logic [7:0] b,
		input logic pend);
		logic [7:0] v;
		v = b;
		if (faulty && $urandom_range(0, 14) == 0)
			send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		if (faulty && $urandom_range(0, 39) == 0)
			v = v ^ 8'($urandom_range(1, 255));
		send_item(m, v, pend);
	endtask

	// APB register write; it is to be only called while the block is idle, and the task does not enforce it.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SESSION_ID: cfg_id = val;
			REG_REQ_LENGTH: cfg_req_len = val[10:0];
			default:        cfg_ticks = val[15:0];
		endcase
	endtask

	// Stops sending and lets every outstanding result drain.
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Sixteen reply header bytes; the caller sets the flag, the length and the last byte's packet end.
	task automatic send_reply_header(input bit faulty, input logic flag,
		input logic [31:0] rlen, input logic pend_end);
		for (int i = 0; i < 16; i++)
			send_noisy(faulty, MODE_RX, (i == 5) ? {7'd0, flag} : header_at(i, HTYPE_REPLY, rlen),
				(i == 15) ? pend_end : 1'b0);
	endtask

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 9))
			0: return 8'd9;
			1: return 8'd10;
			2: return 8'd13;
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	// One whole exchange with the given sizes and random content.
	task automatic run_session(input bit faulty, input int req_len, input int reply_len);
		wait_drained();
		write_reg(REG_REQ_LENGTH, req_len);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_SESSION_ID, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
				{16'($urandom_range(0, 65535)), 16'(($urandom_range(1, 65535)))});
		if (faulty && $urandom_range(0, 3) == 0)
			write_reg(REG_TIMEOUT, $urandom_range(1, 30));
		else
			write_reg(REG_TIMEOUT, 32'hFFFF);
		send_noisy(faulty, MODE_CONF, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_noisy(faulty, MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		for (int i = 0; i < req_len; i++)
			send_noisy(faulty, MODE_REQ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_reply_header(faulty, 1'($urandom_range(0, 1)), reply_len,
			1'($urandom_range(0, 1)));
		for (int i = 0; i < reply_len; i++)
			send_noisy(faulty, MODE_RX, (faulty && $urandom_range(0, 59) == 0) ?
				8'($urandom_range(0, 255)) : text_char(),
				(i == reply_len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0));
		// An excess byte sometimes follows the reply.
		if ($urandom_range(0, 5) == 0)
			send_noisy(faulty, MODE_RX, text_char(), 1'($urandom_range(0, 1)));
		send_noisy(faulty, MODE_LOST, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Short checks of the idle cases, bad requests and sessions ended by a header error, loss, cancel or timeout.
	task automatic test_directed();
		write_reg(REG_REQ_LENGTH, 32'd0);
		send_item(MODE_START, 8'h00, 1'b0);
		wait_drained();
		write_reg(REG_REQ_LENGTH, 32'd2047);
		send_item(MODE_START, 8'hFF, 1'b1);
		wait_drained();
		write_reg(REG_REQ_LENGTH, 32'd1);
		write_reg(REG_SESSION_ID, 32'hFFFF_FFFF);
		send_item(MODE_UNUSED, 8'hFF, 1'b1);
		send_item(MODE_REQ, 8'h55, 1'b0);
		send_item(MODE_RX, 8'hAA, 1'b1);
		send_item(MODE_CANCEL, 8'h00, 1'b0);
		send_item(MODE_LOST, 8'h00, 1'b0);
		send_item(MODE_TICK, 8'h00, 1'b0);
		send_item(MODE_CONF, 8'h00, 1'b0);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_RX, 8'h4B, 1'b0);
		send_item(MODE_REQ, 8'hFF, 1'b1);
		send_item(MODE_RX, 8'h4B, 1'b0);
		send_item(MODE_RX, 8'h41, 1'b1);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_REQ, 8'h00, 1'b0);
		send_item(MODE_LOST, 8'h00, 1'b0);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_CANCEL, 8'h00, 1'b0);
		wait_drained();
		write_reg(REG_TIMEOUT, 32'd1);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_TICK, 8'h00, 1'b0);
	endtask

	// Reply header with a zero length and with one above the limit.
	task automatic test_reply_length();
		wait_drained();
		write_reg(REG_SESSION_ID, 32'd1);
		write_reg(REG_TIMEOUT, 32'hFFFF);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_REQ, 8'h7E, 1'b0);
		send_reply_header(1'b0, 1'b0, 32'd0, 1'b1);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_REQ, 8'h20, 1'b0);
		send_reply_header(1'b0, 1'b1, REPLY_LIMIT + 1, 1'b0);
	endtask

	// Non-printable text byte, an excess byte and a remote flag report.
	task automatic test_reply_text();
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_REQ, 8'h01, 1'b0);
		send_reply_header(1'b0, 1'b0, 32'd2, 1'b0);
		send_item(MODE_RX, 8'h7F, 1'b0);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_REQ, 8'h01, 1'b0);
		send_reply_header(1'b0, 1'b1, 32'd1, 1'b0);
		send_item(MODE_RX, 8'h09, 1'b0);
		send_item(MODE_RX, 8'h0A, 1'b1);
		send_item(MODE_START, 8'h00, 1'b0);
		send_item(MODE_REQ, 8'h01, 1'b0);
		send_reply_header(1'b0, 1'b1, 32'd1, 1'b1);
		send_item(MODE_RX, 8'h0D, 1'b1);
		send_item(MODE_LOST, 8'h00, 1'b0);
	endtask

	// The receiver holds off while a long request keeps arriving.
	task automatic test_backpressure();
		wait_drained();
		hold_go = 1'b1;
		run_session(1'b0, 40, 20);
	endtask

	// Random exchanges, most well formed, some with noise and corruption.
	task automatic test_random_sessions();
		while (items_sent < 280)
			run_session($urandom_range(0, 2) == 0,
				($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 20),
				$urandom_range(1, 24));
	endtask

	// Closing stretch with neither side idling.
	task automatic test_steady();
		wait_drained();
		idle_enable = 1'b0;
		run_session(1'b0, 70, 10);
		run_session(1'b0, 3, 5);
	endtask

	// Long receiver hold-off, counted here in cycles.
	initial begin
		hold_pop = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_pop <= 1'b1;
		repeat (400) @(posedge clk);
		hold_pop <= 1'b0;
	end

	// Result checker and pop driver.
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d byte=%0d end=%0d status=%0d last=%0d",
						$time, kind, out_byte, tx_packet_end, status, last);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (kind !== exp_r.kind || out_byte !== exp_r.out_byte ||
						tx_packet_end !== exp_r.tx_end || status !== exp_r.status ||
						last !== exp_r.last) begin
						$display("%0t: mismatch expected kind=%0d byte=%0d end=%0d status=%0d last=%0d",
							$time, exp_r.kind, exp_r.out_byte, exp_r.tx_end, exp_r.status,
							exp_r.last);
						$display("%0t:          actual kind=%0d byte=%0d end=%0d status=%0d last=%0d",
							$time, kind, out_byte, tx_packet_end, status, last);
						fail_count++;
					end
				end
			end
			if (hold_pop) begin
				pop <= 1'b0;
			end else if (pop_stall > 0) begin
				pop <= 1'b0;
				pop_stall--;
			end else if (idle_enable && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				pop_stall = $urandom_range(0, 6);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		mode = MODE_START;
		data_byte = '0;
		rx_packet_end = 1'b0;
		pop = 1'b0;
		fail_count = 0;
		items_sent = 0;
		cycle_count = 0;
		pop_stall = 0;
		idle_enable = 1'b1;
		hold_go = 1'b0;
		cfg_id = 32'd1;
		cfg_req_len = 11'd1;
		cfg_ticks = 16'd15360;
		s_phase = SS_IDLE;
		s_sent = 0;
		s_hdr_idx = 0;
		s_reply_len = 0;
		s_recv = 0;
		s_remote = 0;
		s_first_pkt = 1;
		s_ticks = 0;
		s_connected = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_reply_length();
		test_reply_text();
		test_backpressure();
		test_random_sessions();
		test_steady();
		wait_drained();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
